@@ src/pipq_pkg.sv @@
package pipq_pkg;

    // field widths fixed by the interface
    localparam int COORD_W   = 16;
    localparam int VERTEX_W  = 2 * COORD_W;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int RSUM_W    = 9;

    // a polygon needs this many vertices before a query is answered
    localparam int MIN_VERTICES = 3;

    // saturation bound of the reported sum, and the sum that means inside
    localparam int SUM_LIMIT  = 128;
    localparam int SUM_INSIDE = 4;

    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_FEW  = 2'd2
    } status_t;

    typedef logic [1:0] quad_t;

    // quadrant of a translated vertex; the axes belong to the quadrant on their positive side
    function automatic quad_t quadrant_of(input logic signed [DIFF_W-1:0] x,
                                          input logic signed [DIFF_W-1:0] y);
        if (!x[DIFF_W-1]) begin
            quadrant_of = y[DIFF_W-1] ? 2'd3 : 2'd0;
        end else begin
            quadrant_of = y[DIFF_W-1] ? 2'd2 : 2'd1;
        end
    endfunction

endpackage

@@ src/point_in_polygon_quadrant.sv @@
// channel   | valid   | ready   | payload
// ----------+---------+---------+-------------------------------------------------------
// request   | s_valid | s_ready | s_kind, s_x_coord, s_y_coord
// result    | m_valid | m_ready | m_inside_res, m_on_boundary, m_winding_sum, m_status
//
// a query reads the ring through the single read port of the vertex memory,
// one vertex per cycle
// aresetn is synchronous, active low; it clears the vertex count, the memory keeps garbage
// one result can wait in the output register while the next request is taken
// a stalled result holds the block in its result state until the register frees up
module point_in_polygon_quadrant #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_kind,
    input  logic signed [pipq_pkg::COORD_W-1:0]  s_x_coord,
    input  logic signed [pipq_pkg::COORD_W-1:0]  s_y_coord,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_inside_res,
    output logic                                 m_on_boundary,
    output logic signed [pipq_pkg::RSUM_W-1:0]   m_winding_sum,
    output logic [1:0]                           m_status
);

    // count must hold MAX_VERTICES itself, the address only indexes the memory
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int ADDR_W = $clog2(MAX_VERTICES);
    // each step moves the sum by at most 2, so 2 bits beyond the count cover the walk
    localparam int SUM_W  = CNT_W + 2;
    localparam int EXT_W  = (SUM_W > pipq_pkg::RSUM_W) ? SUM_W : pipq_pkg::RSUM_W;

    localparam int DW = pipq_pkg::DIFF_W;
    localparam int PW = pipq_pkg::PROD_W;
    localparam int CW = pipq_pkg::COORD_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_RESULT
    } state_t;

    state_t state_reg;

    // ---------------------------------------------------------------------
    // vertex memory: written by appends in idle, read only during the walk,
    // so a read never meets a write to the same entry
    // ---------------------------------------------------------------------
    logic [pipq_pkg::VERTEX_W-1:0] vertex_mem [MAX_VERTICES];
    logic [pipq_pkg::VERTEX_W-1:0] rd_data_reg;
    logic                          mem_we;
    logic [ADDR_W-1:0]             mem_waddr;
    logic                          mem_re;
    logic [ADDR_W-1:0]             mem_raddr;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] elem_reg;       // walk element: 0..n, element n is vertex 0 again
    logic             issuing_reg;

    logic             s_fire;
    logic             table_full;

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign table_full = (count_reg >= CNT_W'(MAX_VERTICES));

    assign mem_we    = s_fire && (s_kind == pipq_pkg::KIND_APPEND) && !table_full;
    assign mem_waddr = count_reg[ADDR_W-1:0];
    assign mem_re    = (state_reg == ST_WALK) && issuing_reg;
    assign mem_raddr = (elem_reg == count_reg) ? '0 : elem_reg[ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            vertex_mem[mem_waddr] <= {s_x_coord, s_y_coord};
        end
        if (mem_re) begin
            rd_data_reg <= vertex_mem[mem_raddr];
        end
    end

    // ---------------------------------------------------------------------
    // walk pipeline
    //   stage 1: memory data
    //   stage 2: translate to the query point
    //   stage 3: pair with previous vertex, cross-product halves
    //   then: boundary check and quadrant step into the sum
    // ---------------------------------------------------------------------
    logic v1_reg, first1_reg, last1_reg;
    logic v2_reg, first2_reg, last2_reg;
    logic v3_reg, last3_reg;

    logic signed [CW-1:0] px_reg, py_reg;
    logic signed [DW-1:0] dx2_reg, dy2_reg;
    logic signed [DW-1:0] prev_x_reg, prev_y_reg;
    logic signed [DW-1:0] ax3_reg, ay3_reg, bx3_reg, by3_reg;
    logic signed [PW-1:0] p1_reg, p2_reg;

    logic signed [DW-1:0] vx_ext, vy_ext, px_ext, py_ext;

    assign vx_ext = {rd_data_reg[2*CW-1], rd_data_reg[2*CW-1:CW]};
    assign vy_ext = {rd_data_reg[CW-1], rd_data_reg[CW-1:0]};
    assign px_ext = {px_reg[CW-1], px_reg};
    assign py_ext = {py_reg[CW-1], py_reg};

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            px_reg <= s_x_coord;
            py_reg <= s_y_coord;
        end
        if (v1_reg) begin
            dx2_reg <= vx_ext - px_ext;
            dy2_reg <= vy_ext - py_ext;
        end
        if (v2_reg) begin
            prev_x_reg <= dx2_reg;
            prev_y_reg <= dy2_reg;
            ax3_reg    <= prev_x_reg;
            ay3_reg    <= prev_y_reg;
            bx3_reg    <= dx2_reg;
            by3_reg    <= dy2_reg;
            p1_reg     <= dy2_reg * prev_x_reg;
            p2_reg     <= dx2_reg * prev_y_reg;
        end
    end

    // edge evaluation on the stage 3 registers
    logic                    hit_vertex, hit_edge, hit;
    logic                    x_apart, y_apart;
    pipq_pkg::quad_t         qa, qb, qd;
    logic signed [2:0]       step;
    logic                    bnd_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic                    bnd_new;
    logic signed [SUM_W-1:0] sum_new;
    logic signed [EXT_W-1:0] sum_ext;
    logic signed [EXT_W-1:0] sum_sat;
    logic                    inside_new;

    // a*b <= 0 without a multiplier: one is zero or the signs differ
    assign x_apart    = (ax3_reg == '0) || (bx3_reg == '0) || (ax3_reg[DW-1] != bx3_reg[DW-1]);
    assign y_apart    = (ay3_reg == '0) || (by3_reg == '0) || (ay3_reg[DW-1] != by3_reg[DW-1]);
    assign hit_vertex = (bx3_reg == '0) && (by3_reg == '0);
    assign hit_edge   = (p1_reg == p2_reg) && x_apart && y_apart;
    assign hit        = hit_vertex || hit_edge;

    assign qa = pipq_pkg::quadrant_of(ax3_reg, ay3_reg);
    assign qb = pipq_pkg::quadrant_of(bx3_reg, by3_reg);
    assign qd = qb - qa;

    always_comb begin
        case (qd)
            2'd1:    step = 3'sd1;
            2'd3:    step = -3'sd1;
            // opposite quadrant: cross-product sign picks the way round
            2'd2:    step = (p1_reg > p2_reg) ? 3'sd2 : -3'sd2;
            default: step = 3'sd0;
        endcase
    end

    assign bnd_new = bnd_reg || hit;
    assign sum_new = bnd_new ? sum_reg : (sum_reg + {{(SUM_W-3){step[2]}}, step});

    // saturate into the 9-bit result range
    assign sum_ext = EXT_W'(sum_new);
    always_comb begin
        if (sum_ext > EXT_W'(pipq_pkg::SUM_LIMIT)) begin
            sum_sat = EXT_W'(pipq_pkg::SUM_LIMIT);
        end else if (sum_ext < -EXT_W'(pipq_pkg::SUM_LIMIT)) begin
            sum_sat = -EXT_W'(pipq_pkg::SUM_LIMIT);
        end else begin
            sum_sat = sum_ext;
        end
    end
    assign inside_new = (sum_sat == EXT_W'(pipq_pkg::SUM_INSIDE))
                     || (sum_sat == -EXT_W'(pipq_pkg::SUM_INSIDE));

    // ---------------------------------------------------------------------
    // control: state, walk bookkeeping and output register
    // ---------------------------------------------------------------------
    logic                               res_inside_reg;
    logic                               res_bnd_reg;
    logic signed [pipq_pkg::RSUM_W-1:0] res_sum_reg;
    pipq_pkg::status_t                  res_status_reg;

    logic                               m_valid_reg;
    logic                               m_inside_reg;
    logic                               m_bnd_reg;
    logic signed [pipq_pkg::RSUM_W-1:0] m_sum_reg;
    pipq_pkg::status_t                  m_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            elem_reg    <= '0;
            issuing_reg <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            first1_reg  <= 1'b0;
            first2_reg  <= 1'b0;
            last1_reg   <= 1'b0;
            last2_reg   <= 1'b0;
            last3_reg   <= 1'b0;
            bnd_reg     <= 1'b0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // pipeline valids move every cycle; first element only seeds the previous vertex
            v1_reg     <= mem_re;
            first1_reg <= (elem_reg == '0);
            last1_reg  <= (elem_reg == count_reg);
            v2_reg     <= v1_reg;
            first2_reg <= first1_reg;
            last2_reg  <= last1_reg;
            v3_reg     <= v2_reg && !first2_reg;
            last3_reg  <= last2_reg;

            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        res_inside_reg <= 1'b0;
                        res_bnd_reg    <= 1'b0;
                        res_sum_reg    <= '0;
                        res_status_reg <= pipq_pkg::STATUS_OK;
                        state_reg      <= ST_RESULT;
                        if (s_kind == pipq_pkg::KIND_APPEND) begin
                            if (table_full) begin
                                res_status_reg <= pipq_pkg::STATUS_FULL;
                            end else begin
                                count_reg <= count_reg + 1'b1;
                            end
                        end else if (count_reg < CNT_W'(pipq_pkg::MIN_VERTICES)) begin
                            res_status_reg <= pipq_pkg::STATUS_FEW;
                        end else begin
                            elem_reg    <= '0;
                            issuing_reg <= 1'b1;
                            bnd_reg     <= 1'b0;
                            sum_reg     <= '0;
                            state_reg   <= ST_WALK;
                        end
                    end
                end
                ST_WALK: begin
                    if (issuing_reg) begin
                        elem_reg <= elem_reg + 1'b1;
                        if (elem_reg == count_reg) begin
                            issuing_reg <= 1'b0;
                        end
                    end
                    if (v3_reg) begin
                        bnd_reg <= bnd_new;
                        sum_reg <= sum_new;
                        if (last3_reg) begin
                            // closing edge done: latch the verdict
                            res_bnd_reg    <= bnd_new;
                            res_inside_reg <= !bnd_new && inside_new;
                            res_sum_reg    <= bnd_new ? '0 : sum_sat[pipq_pkg::RSUM_W-1:0];
                            res_status_reg <= pipq_pkg::STATUS_OK;
                            state_reg      <= ST_RESULT;
                        end
                    end
                end
                ST_RESULT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_inside_reg <= res_inside_reg;
                        m_bnd_reg    <= res_bnd_reg;
                        m_sum_reg    <= res_sum_reg;
                        m_status_reg <= res_status_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_inside_res  = m_inside_reg;
    assign m_on_boundary = m_bnd_reg;
    assign m_winding_sum = m_sum_reg;
    assign m_status      = m_status_reg;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

// expected answers for the polygon block: keeps its own copy of the vertex ring
class winding_scoreboard;

    typedef struct packed {
        logic                                   in_poly;
        logic                                   boundary;
        logic signed [pipq_pkg::RSUM_W-1:0]     wind;
        pipq_pkg::status_t                      status;
    } answer_t;

    int unsigned                                capacity;
    logic signed [pipq_pkg::COORD_W-1:0]        vert_x[];
    logic signed [pipq_pkg::COORD_W-1:0]        vert_y[];
    int unsigned                                vert_count;
    answer_t                                    answers_due[$];

    int unsigned faults;
    int unsigned appends, dropped, queries, short_rings, inside_hits, boundary_hits;
    int          widest_wind;

    function new(int unsigned slots);
        capacity      = slots;
        vert_x        = new[slots];
        vert_y        = new[slots];
        vert_count    = 0;
        faults        = 0;
        appends       = 0;
        dropped       = 0;
        queries       = 0;
        short_rings   = 0;
        inside_hits   = 0;
        boundary_hits = 0;
        widest_wind   = 0;
    endfunction

    function int quadrant(longint x, longint y);
        if (x >= 0) begin
            return (y >= 0) ? 0 : 3;
        end
        return (y >= 0) ? 1 : 2;
    endfunction

    // quadrant walk around the ring, translated so the query point is the origin
    function answer_t wind_query(logic signed [pipq_pkg::COORD_W-1:0] px,
                                 logic signed [pipq_pkg::COORD_W-1:0] py);
        answer_t     a;
        longint      ax, ay, bx, by, f;
        int          qa, qb, wind;
        int unsigned i, j;
        bit          hit;
        a.in_poly  = 1'b0;
        a.boundary = 1'b0;
        a.wind     = '0;
        a.status   = pipq_pkg::STATUS_OK;
        queries++;
        if (vert_count < pipq_pkg::MIN_VERTICES) begin
            a.status = pipq_pkg::STATUS_FEW;
            short_rings++;
            return a;
        end
        ax   = longint'(vert_x[0]) - longint'(px);
        ay   = longint'(vert_y[0]) - longint'(py);
        qa   = quadrant(ax, ay);
        wind = 0;
        hit  = 1'b0;
        for (i = 1; i <= vert_count && !hit; i++) begin
            j  = (i < vert_count) ? i : 0;
            bx = longint'(vert_x[j]) - longint'(px);
            by = longint'(vert_y[j]) - longint'(py);
            f  = by * ax - bx * ay;
            if ((bx == 0 && by == 0) || (f == 0 && ax * bx <= 0 && ay * by <= 0)) begin
                hit = 1'b1;
            end else begin
                qb = quadrant(bx, by);
                if (qb == ((qa + 1) & 3)) begin
                    wind += 1;
                end else if (qb == ((qa + 3) & 3)) begin
                    wind -= 1;
                end else if (qb == ((qa + 2) & 3)) begin
                    wind += (f > 0) ? 2 : -2;
                end
                qa = qb;
                ax = bx;
                ay = by;
            end
        end
        if (hit) begin
            a.boundary = 1'b1;
            boundary_hits++;
        end else begin
            if (wind > pipq_pkg::SUM_LIMIT) wind = pipq_pkg::SUM_LIMIT;
            if (wind < -pipq_pkg::SUM_LIMIT) wind = -pipq_pkg::SUM_LIMIT;
            a.wind    = wind[pipq_pkg::RSUM_W-1:0];
            a.in_poly = (wind == pipq_pkg::SUM_INSIDE || wind == -pipq_pkg::SUM_INSIDE);
            if (a.in_poly) inside_hits++;
            if (wind > widest_wind) widest_wind = wind;
            if (-wind > widest_wind) widest_wind = -wind;
        end
        return a;
    endfunction

    function void accept_request(logic kind,
                                 logic signed [pipq_pkg::COORD_W-1:0] x,
                                 logic signed [pipq_pkg::COORD_W-1:0] y);
        answer_t a;
        if (kind == pipq_pkg::KIND_APPEND) begin
            a.in_poly  = 1'b0;
            a.boundary = 1'b0;
            a.wind     = '0;
            a.status   = pipq_pkg::STATUS_OK;
            appends++;
            if (vert_count < capacity) begin
                vert_x[vert_count] = x;
                vert_y[vert_count] = y;
                vert_count++;
            end else begin
                a.status = pipq_pkg::STATUS_FULL;
                dropped++;
            end
        end else begin
            a = wind_query(x, y);
        end
        answers_due.push_back(a);
    endfunction

    function void check_result(logic in_poly, logic boundary,
                               logic signed [pipq_pkg::RSUM_W-1:0] wind, logic [1:0] status);
        answer_t a;
        if (answers_due.size() == 0) begin
            $error("result arrived with no request outstanding");
            faults++;
            return;
        end
        a = answers_due.pop_front();
        if (in_poly !== a.in_poly) begin
            $error("inside_res: expected %0d, got %0d", a.in_poly, in_poly);
            faults++;
        end
        if (boundary !== a.boundary) begin
            $error("on_boundary: expected %0d, got %0d", a.boundary, boundary);
            faults++;
        end
        if (wind !== a.wind) begin
            $error("winding_sum: expected %0d, got %0d", a.wind, wind);
            faults++;
        end
        if (status !== a.status) begin
            $error("status: expected %0d, got %0d", a.status, status);
            faults++;
        end
    endfunction

endclass

module testbench;

    localparam int POLY_SLOTS      = 64;
    localparam int C_MAX           = 2 ** (pipq_pkg::COORD_W - 1) - 1;
    localparam int C_MIN           = -(2 ** (pipq_pkg::COORD_W - 1));
    localparam int RANDOM_REQUESTS = 1950;
    // idling phases, reckoned in requests sent and in results taken
    localparam int PHASE1_END      = 700;
    localparam int PHASE2_END      = 1400;
    // long result back-pressure, started when this many results have been taken
    localparam int HOLD_FIRST      = 400;
    localparam int HOLD_EVERY      = 1100;
    localparam int HOLD_CYCLES     = 400;
    localparam int TAIL_CYCLES     = POLY_SLOTS + 16;
    localparam int QUIET_LIMIT     = 3000;

    logic                                 aclk     = 1'b0;
    logic                                 aresetn  = 1'b0;
    logic                                 s_valid  = 1'b0;
    logic                                 s_ready;
    logic                                 s_kind   = pipq_pkg::KIND_APPEND;
    logic signed [pipq_pkg::COORD_W-1:0]  s_x_coord = '0;
    logic signed [pipq_pkg::COORD_W-1:0]  s_y_coord = '0;
    logic                                 m_valid;
    logic                                 m_ready  = 1'b0;
    logic                                 m_inside_res;
    logic                                 m_on_boundary;
    logic signed [pipq_pkg::RSUM_W-1:0]   m_winding_sum;
    logic [1:0]                           m_status;

    winding_scoreboard           winding_sb;
    int unsigned                 requests_sent = 0;
    int unsigned                 results_taken = 0;

    point_in_polygon_quadrant #(
        .MAX_VERTICES(POLY_SLOTS)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_x_coord     (s_x_coord),
        .s_y_coord     (s_y_coord),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_inside_res  (m_inside_res),
        .m_on_boundary (m_on_boundary),
        .m_winding_sum (m_winding_sum),
        .m_status      (m_status)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // one request: optional idle gap, then hold valid until the block takes it
    task automatic send_request(input logic kind, input int x, input int y);
        int unsigned gap_pct;
        gap_pct = (requests_sent < PHASE1_END) ? 28 : (requests_sent < PHASE2_END) ? 45 : 0;
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_kind    <= kind;
        s_x_coord <= x[pipq_pkg::COORD_W-1:0];
        s_y_coord <= y[pipq_pkg::COORD_W-1:0];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // request taken at this edge
        winding_sb.accept_request(kind, x[pipq_pkg::COORD_W-1:0], y[pipq_pkg::COORD_W-1:0]);
        requests_sent++;
    endtask

    // sender goes quiet until every outstanding answer has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (winding_sb.answers_due.size() != 0) @(posedge aclk);
    endtask

    // unit step along one of eight headings, counterclockwise from +x
    function automatic int heading_x(int h);
        case (h & 7)
            0, 1, 7: return 1;
            3, 4, 5: return -1;
            default: return 0;
        endcase
    endfunction

    // result side: check every accepted result, then pick the next ready value
    int unsigned stall_left = 0;
    int unsigned next_hold  = HOLD_FIRST;

    always @(posedge aclk) begin
        int unsigned idle_pct;
        if (m_valid && m_ready) begin
            winding_sb.check_result(m_inside_res, m_on_boundary, m_winding_sum, m_status);
            results_taken++;
        end
        idle_pct = (results_taken < PHASE1_END) ? 45 : (results_taken < PHASE2_END) ? 28 : 0;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            // long back-pressure: the block has to fill up and stall its input
            m_ready <= 1'b0;
            stall_left--;
        end else if (results_taken >= next_hold) begin
            m_ready    <= 1'b0;
            stall_left = HOLD_CYCLES - 1;
            next_hold  += HOLD_EVERY;
        end else begin
            m_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // ends the run when nothing moves on either channel for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[point_in_polygon_quadrant] ERROR");
        $finish;
    end

    initial begin
        int unsigned n, i, j, sel, spiral_done;
        int          qx, qy, r, heading, cx, cy;

        winding_sb = new(POLY_SLOTS);
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // ---- directed part ----
        // queries on an empty and on a too-short ring
        send_request(pipq_pkg::KIND_QUERY, 0, 0);
        send_request(pipq_pkg::KIND_APPEND, C_MIN, C_MIN);
        send_request(pipq_pkg::KIND_QUERY, C_MIN, C_MIN);
        send_request(pipq_pkg::KIND_APPEND, C_MAX, C_MIN);
        send_request(pipq_pkg::KIND_QUERY, 1, 1);
        send_request(pipq_pkg::KIND_APPEND, C_MAX, C_MAX);
        // triangle: its closing edge runs along y = x through the origin
        send_request(pipq_pkg::KIND_QUERY, 0, 0);
        send_request(pipq_pkg::KIND_QUERY, 100, -100);
        send_request(pipq_pkg::KIND_QUERY, -100, 100);
        // full-range square, counterclockwise
        send_request(pipq_pkg::KIND_APPEND, C_MIN, C_MAX);
        send_request(pipq_pkg::KIND_QUERY, 0, 0);
        send_request(pipq_pkg::KIND_QUERY, -1, -1);
        send_request(pipq_pkg::KIND_QUERY, C_MIN + 1, C_MAX - 1);
        // vertex hits, the first vertex among them (found only on the closing step)
        send_request(pipq_pkg::KIND_QUERY, C_MAX, C_MAX);
        send_request(pipq_pkg::KIND_QUERY, C_MAX, C_MIN);
        send_request(pipq_pkg::KIND_QUERY, C_MIN, C_MIN);
        // edge hits on each kind of side
        send_request(pipq_pkg::KIND_QUERY, 0, C_MIN);
        send_request(pipq_pkg::KIND_QUERY, C_MIN, 5);
        send_request(pipq_pkg::KIND_QUERY, C_MAX, 0);
        send_request(pipq_pkg::KIND_QUERY, -7, C_MAX);

        // ---- random part ----
        // the ring grows as a wandering spiral around a random center until the table
        // is full; later appends are dropped, and queries aim at the inside, the
        // vertices, the edges and points on the lines of the edges
        cx          = 2 * $urandom_range(0, 4000) - 4000;
        cy          = 2 * $urandom_range(0, 4000) - 4000;
        heading     = 0;
        spiral_done = 0;
        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n == 900 || n == 1600) begin
                drain_results();
            end
            sel = $urandom_range(99);
            if (winding_sb.vert_count < POLY_SLOTS && sel < 40) begin
                r  = 2 * $urandom_range(1000, 6000);
                qx = cx + heading_x(heading) * r + 2 * $urandom_range(0, 200) - 200;
                qy = cy + heading_x((heading + 6) & 7) * r + 2 * $urandom_range(0, 200) - 200;
                send_request(pipq_pkg::KIND_APPEND, qx, qy);
                // one turn counterclockwise, two turns back, then a random walk
                if (spiral_done < 8) begin
                    heading = (heading + 1) & 7;
                end else if (spiral_done < 24) begin
                    heading = (heading + 7) & 7;
                end else begin
                    heading = (heading + ($urandom_range(1) ? 1 : 7)) & 7;
                end
                spiral_done++;
            end else if (winding_sb.vert_count >= POLY_SLOTS && sel < 5) begin
                send_request(pipq_pkg::KIND_APPEND, $urandom, $urandom);
            end else begin
                i   = $urandom_range(winding_sb.vert_count - 1);
                j   = (i + 1) % winding_sb.vert_count;
                sel = $urandom_range(99);
                if (sel < 35) begin
                    qx = cx + $urandom_range(0, 28000) - 14000;
                    qy = cy + $urandom_range(0, 28000) - 14000;
                end else if (sel < 50) begin
                    qx = int'($signed(16'($urandom)));
                    qy = int'($signed(16'($urandom)));
                end else if (sel < 65) begin
                    qx = winding_sb.vert_x[i];
                    qy = winding_sb.vert_y[i];
                end else if (sel < 80) begin
                    // midpoint of an edge, on it whenever the sums are even
                    qx = (int'(winding_sb.vert_x[i]) + int'(winding_sb.vert_x[j])) >>> 1;
                    qy = (int'(winding_sb.vert_y[i]) + int'(winding_sb.vert_y[j])) >>> 1;
                end else if (sel < 90) begin
                    // on the line of an edge but past its end
                    qx = 2 * int'(winding_sb.vert_x[j]) - int'(winding_sb.vert_x[i]);
                    qy = 2 * int'(winding_sb.vert_y[j]) - int'(winding_sb.vert_y[i]);
                end else begin
                    // at most one step off a vertex
                    qx = int'(winding_sb.vert_x[i]) + $urandom_range(2) - 1;
                    qy = int'(winding_sb.vert_y[i]) + $urandom_range(2) - 1;
                end
                if (qx > C_MAX || qx < C_MIN || qy > C_MAX || qy < C_MIN) begin
                    qx = winding_sb.vert_x[i];
                    qy = winding_sb.vert_y[i];
                end
                send_request(pipq_pkg::KIND_QUERY, qx, qy);
            end
        end

        // let the last answers arrive, then make sure nothing extra follows
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d requests: %0d appends (%0d dropped on a full ring), %0d queries",
                 requests_sent, winding_sb.appends, winding_sb.dropped, winding_sb.queries);
        $display("answers: %0d inside, %0d on the boundary, %0d short ring, widest sum %0d",
                 winding_sb.inside_hits, winding_sb.boundary_hits, winding_sb.short_rings,
                 winding_sb.widest_wind);
        if (winding_sb.faults == 0) begin
            $display("[point_in_polygon_quadrant] OK");
        end else begin
            $display("[point_in_polygon_quadrant] ERROR");
        end
        $finish;
    end

endmodule
